// ===== rtl/core/chd_pkg.sv =====
// Shared types, character codes and helper functions for the chunked body decoder.
package chd_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam int unsigned HEX_RADIX_BITS = 4;

    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_DATA = 2'd1,
        PH_TAIL = 2'd2
    } chd_phase_t;

    typedef struct packed {
        chd_phase_t phase;
        logic       digit_seen;
        logic       number_closed;
        logic       size_overflow;
        logic       done_flag;
        logic       error_flag;
    } chd_state_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       finished;
        logic       bad_size;
    } chd_result_t;

    typedef struct packed {
        logic                        is_hex;
        logic [HEX_RADIX_BITS-1:0]   value;
    } chd_hex_t;

    function automatic chd_hex_t hex_decode(input logic [7:0] b);
        chd_hex_t h;
        h.is_hex = 1'b0;
        h.value  = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.is_hex = 1'b1;
            h.value  = 4'(b - 8'h30);
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            h.is_hex = 1'b1;
            h.value  = 4'(b - 8'h37);
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            h.is_hex = 1'b1;
            h.value  = 4'(b - 8'h57);
        end
        return h;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF);
    endfunction

endpackage

// ===== rtl/core/chd_step.sv =====
// Next-state and result logic for one body byte of the chunked decoder.
module chd_step #(
    parameter int SIZE_BITS = 32
) (
    input  chd_pkg::chd_state_t  state,
    input  logic [SIZE_BITS-1:0] bytes_left,
    input  logic [7:0]           in_byte,
    output chd_pkg::chd_state_t  state_next,
    output logic [SIZE_BITS-1:0] bytes_left_next,
    output chd_pkg::chd_result_t result
);
    import chd_pkg::*;

    chd_hex_t             hex;
    logic [SIZE_BITS-1:0] count_dec;
    logic                 top_busy;

    assign hex       = hex_decode(in_byte);
    assign count_dec = bytes_left - SIZE_BITS'(1);
    assign top_busy  = (bytes_left[SIZE_BITS-1 -: HEX_RADIX_BITS] != '0);

    always_comb
    begin
        state_next      = state;
        bytes_left_next = bytes_left;
        result.out_valid = 1'b0;
        result.out_byte  = '0;

        if (!state.done_flag) begin
            case (state.phase)
                PH_DATA:
                begin
                    result.out_valid = 1'b1;
                    result.out_byte  = in_byte;
                    if (bytes_left != '0) begin
                        bytes_left_next = count_dec;
                    end
                    if (bytes_left <= SIZE_BITS'(1)) begin
                        state_next.phase = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    if (in_byte == CHAR_LF) begin
                        state_next.phase = PH_SIZE;
                    end
                end
                default:
                begin
                    state_next.phase = PH_SIZE;
                    if (in_byte == CHAR_CR) begin
                        // Carriage return is dropped without closing the number.
                    end
                    else if (in_byte == CHAR_LF) begin
                        if (!state.digit_seen || state.size_overflow) begin
                            state_next.done_flag  = 1'b1;
                            state_next.error_flag = 1'b1;
                            bytes_left_next       = '0;
                        end
                        else if (bytes_left == '0) begin
                            state_next.done_flag = 1'b1;
                        end
                        else begin
                            state_next.phase = PH_DATA;
                        end
                        state_next.digit_seen    = 1'b0;
                        state_next.number_closed = 1'b0;
                        state_next.size_overflow = 1'b0;
                    end
                    else if (state.number_closed) begin
                        // Extensions after the number are ignored up to the line end.
                    end
                    else if (!state.digit_seen && is_blank(in_byte)) begin
                        // Leading white space is skipped.
                    end
                    else if (!hex.is_hex || in_byte == CHAR_SEMI) begin
                        state_next.number_closed = 1'b1;
                    end
                    else begin
                        state_next.digit_seen = 1'b1;
                        if (!state.size_overflow) begin
                            if (top_busy) begin
                                state_next.size_overflow = 1'b1;
                            end
                            else begin
                                bytes_left_next = {bytes_left[SIZE_BITS-HEX_RADIX_BITS-1:0],
                                                   hex.value};
                            end
                        end
                    end
                end
            endcase
        end

        result.finished = state_next.done_flag;
        result.bad_size = state_next.error_flag;
    end

endmodule

// ===== rtl/core/chd_outbuf.sv =====
// Two-entry output buffer that holds results while the downstream side stalls.
module chd_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  chd_pkg::chd_result_t push_data,
    output logic                 can_push,
    output logic                 head_valid,
    input  logic                 pop,
    output chd_pkg::chd_result_t head_data
);
    import chd_pkg::*;

    logic        head_vld_reg;
    logic        head_vld_next;
    chd_result_t head_reg;
    chd_result_t head_next;
    logic        skid_vld_reg;
    logic        skid_vld_next;
    chd_result_t skid_reg;
    chd_result_t skid_next;
    logic        head_free;

    assign head_free  = !head_vld_reg || pop;
    assign can_push   = !skid_vld_reg;
    assign head_valid = head_vld_reg;
    assign head_data  = head_reg;

    always_comb
    begin
        head_vld_next = head_vld_reg;
        head_next     = head_reg;
        skid_vld_next = skid_vld_reg;
        skid_next     = skid_reg;
        if (head_free) begin
            if (skid_vld_reg) begin
                head_vld_next = 1'b1;
                head_next     = skid_reg;
                skid_vld_next = 1'b0;
            end
            else begin
                head_vld_next = push;
                head_next     = push_data;
            end
        end
        else if (push) begin
            skid_vld_next = 1'b1;
            skid_next     = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else begin
            head_vld_reg <= head_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> head_vld_reg)
        else $error("Skid entry holds a result while the head entry is empty.");

    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        head_vld_reg && !pop |=> head_vld_reg && $stable(head_reg))
        else $error("Head result changed before it was transferred.");

endmodule

// ===== rtl/core/http_chunked_body_decoder.sv =====
// Top level of the chunked body decoder: state registers, step logic and output buffer.
// The decoder takes one body byte per clock cycle while in_ready is high and gives one
// result per byte; each result is registered in the output buffer before it is offered
// on the result port. Each byte needs only a hex shift-in or a decrement of the chunk
// counter on the state registers. A two-entry output buffer keeps input transfers going
// while the result side stalls; in_ready falls only when both entries are full.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       finished,
    output logic       bad_size
);
    import chd_pkg::*;

    chd_state_t           state_reg;
    chd_state_t           state_next;
    logic [SIZE_BITS-1:0] bytes_left_reg;
    logic [SIZE_BITS-1:0] bytes_left_next;
    chd_result_t          step_result;
    chd_result_t          head_data;
    logic                 in_fire;
    logic                 res_fire;

    assign in_fire  = in_valid && in_ready;
    assign res_fire = res_valid && res_ready;

    chd_step #(
        .SIZE_BITS(SIZE_BITS)
    ) u_step (
        .state          (state_reg),
        .bytes_left     (bytes_left_reg),
        .in_byte        (in_byte),
        .state_next     (state_next),
        .bytes_left_next(bytes_left_next),
        .result         (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= '{phase: PH_SIZE, default: 1'b0};
            bytes_left_reg <= '0;
        end
        else if (in_fire) begin
            state_reg      <= state_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    chd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (step_result),
        .can_push  (in_ready),
        .head_valid(res_valid),
        .pop       (res_fire),
        .head_data (head_data)
    );

    assign out_valid = head_data.out_valid;
    assign out_byte  = head_data.out_byte;
    assign finished  = head_data.finished;
    assign bad_size  = head_data.bad_size;

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.done_flag |=> state_reg.done_flag)
        else $error("Finished flag cleared without reset.");

    a_error_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error_flag |-> state_reg.done_flag)
        else $error("Bad size flagged while decoding is still running.");

    a_data_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_DATA && !state_reg.done_flag |-> bytes_left_reg != '0)
        else $error("Data phase entered with an empty chunk counter.");

endmodule
